// ===== design/iir_pkg.sv =====
package iir_pkg;

    localparam int COEF_BITS  = 18;
    localparam int STATE_BITS = 40;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_COEF_0   = 3'd0,
        REG_FF_COEF_1   = 3'd1,
        REG_FF_COEF_2   = 3'd2,
        REG_FB_COEF_1   = 3'd3,
        REG_FB_COEF_2   = 3'd4,
        REG_INIT_GAIN_0 = 3'd5,
        REG_INIT_GAIN_1 = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G0,
        ST_G1,
        ST_B0,
        ST_Y,
        ST_A1,
        ST_B2,
        ST_A2,
        ST_S1
    } seq_state_t;

endpackage

// ===== design/iir_filter_with_initial_state.sv =====
// Second-order recursive (biquad) filter, transposed direct form II (first-order
// when FILTER_ORDER is below 2), with Q3.14 coefficients b0..b2, a1, a2 and start
// gains g0, g1 written through the cfg_ port; the user must write them only while
// the block is idle, which the block itself does not enforce. One 18 x SAMPLE_BITS
// multiplier is shared by all products and runs one product per cycle under a
// small sequencer; an item passes states B0, Y, A1, B2, A2 and S1 on its way to
// the result register, with G0 and G1 ahead of them when it is marked first_sample
// (two extra products load the delay states with g0*x and g1*x). The block takes
// one item at a time: s_ready is high only in the idle state, and an item
// finishing while the previous result is still untaken waits for that result to
// transfer. Output is rounded half up and saturated to SAMPLE_BITS, with
// m_clipped set when it saturated.
module iir_filter_with_initial_state #(
    parameter int FILTER_ORDER   = 2,
    parameter int COEF_FRAC_BITS = 14,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [iir_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [iir_pkg::COEF_BITS-1:0]          cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample_in,
    input  logic                                   s_first_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_sample_out,
    output logic                                   m_clipped
);
    import iir_pkg::*;

    localparam int  PROD_W   = COEF_BITS + SAMPLE_BITS;
    localparam int  WIDE_W   = (STATE_BITS > PROD_W) ? STATE_BITS : PROD_W;
    localparam int  ACC_W    = WIDE_W + 2;
    localparam bit  ORDER2   = (FILTER_ORDER >= 2);

    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] ROUND =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS-1);

    // configuration
    logic signed [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, g0_reg, g1_reg;

    // sequencer and datapath
    seq_state_t                  state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg;
    logic                        first_reg, clip_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [STATE_BITS-1:0] s0_reg, s1_reg;
    logic                        m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                        out_clip_reg;

    logic signed [COEF_BITS-1:0]   mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_opnd;
    logic signed [PROD_W-1:0]      mul_prod;
    logic signed [ACC_W-1:0]       prod_ext, s0_ext, s1_ext;
    logic signed [ACC_W-1:0]       y_sum, y_shift, sat_src;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_clip;
    logic signed [STATE_BITS-1:0]  s_sat;
    logic                          in_xfer, out_free;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= COEF_BITS'(1) << COEF_FRAC_BITS;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
            g0_reg <= '0;
            g1_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_FF_COEF_0:   b0_reg <= cfg_data;
                REG_FF_COEF_1:   b1_reg <= cfg_data;
                REG_FF_COEF_2:   b2_reg <= cfg_data;
                REG_FB_COEF_1:   a1_reg <= cfg_data;
                REG_FB_COEF_2:   a2_reg <= cfg_data;
                REG_INIT_GAIN_0: g0_reg <= cfg_data;
                REG_INIT_GAIN_1: g1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier: operand choice follows the sequencer
    always_comb begin
        mul_coef = b0_reg;
        mul_opnd = x_reg;
        case (state_reg)
            ST_G0:   mul_coef = g0_reg;
            ST_G1:   mul_coef = g1_reg;
            ST_B0:   mul_coef = b0_reg;
            ST_Y:    mul_coef = b1_reg;
            ST_A1: begin
                mul_coef = a1_reg;
                mul_opnd = y_reg;
            end
            ST_B2:   mul_coef = b2_reg;
            ST_A2: begin
                mul_coef = a2_reg;
                mul_opnd = y_reg;
            end
            default: mul_coef = b0_reg;
        endcase
    end

    assign mul_prod = mul_coef * mul_opnd;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign s0_ext   = {{(ACC_W-STATE_BITS){s0_reg[STATE_BITS-1]}}, s0_reg};
    assign s1_ext   = {{(ACC_W-STATE_BITS){s1_reg[STATE_BITS-1]}}, s1_reg};

    // output: round half up, floor shift, saturate
    always_comb begin
        y_sum   = prod_ext + s0_ext + ROUND;
        y_shift = y_sum >>> COEF_FRAC_BITS;
        y_clip  = 1'b1;
        if (y_shift > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (y_shift < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat  = y_shift[SAMPLE_BITS-1:0];
            y_clip = 1'b0;
        end
    end

    // one state saturator shared by every delay-state write
    always_comb begin
        case (state_reg)
            ST_G1, ST_B0: sat_src = prod_ext;
            ST_B2, ST_S1: sat_src = acc_reg - prod_ext;
            default:      sat_src = prod_ext;
        endcase
        if (sat_src > S_MAX) begin
            s_sat = S_MAX[STATE_BITS-1:0];
        end else if (sat_src < S_MIN) begin
            s_sat = S_MIN[STATE_BITS-1:0];
        end else begin
            s_sat = sat_src[STATE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = s_first_sample ? ST_G0 : ST_B0;
                end
            end
            ST_G0:   state_next = ST_G1;
            ST_G1:   state_next = ST_B0;
            ST_B0:   state_next = ST_Y;
            ST_Y:    state_next = ST_A1;
            ST_A1:   state_next = ST_B2;
            ST_B2:   state_next = ST_A2;
            ST_A2:   state_next = ST_S1;
            ST_S1: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg      <= '0;
            s1_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_S1 && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_G1: s0_reg <= s_sat;
                ST_B0: begin
                    if (first_reg && ORDER2) begin
                        s1_reg <= s_sat;
                    end
                end
                ST_B2: s0_reg <= s_sat;
                ST_S1: begin
                    if (out_free) begin
                        s1_reg <= ORDER2 ? s_sat : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_reg     <= s_sample_in;
            first_reg <= s_first_sample;
        end
        // hold the last product while waiting to hand over the result
        if (state_reg != ST_S1) begin
            prod_reg <= mul_prod;
        end
        case (state_reg)
            ST_Y: begin
                y_reg    <= y_sat;
                clip_reg <= y_clip;
            end
            ST_A1:   acc_reg <= prod_ext + (ORDER2 ? s1_ext : '0);
            ST_A2:   acc_reg <= prod_ext;
            ST_S1: begin
                if (out_free) begin
                    out_sample_reg <= y_reg;
                    out_clip_reg   <= clip_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_clipped    = out_clip_reg;

endmodule

// ===== design/iir_checker.sv =====
module iir_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input logic                          m_clipped
);

    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // one item at a time: no new transfer straight after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // a result cannot appear too soon after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready, 1) && !$past(s_valid && s_ready, 2))
        else $error("result appeared too soon after input");

    // clipping flag only on a saturated value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> (m_sample_out == OUT_MAX) || (m_sample_out == OUT_MIN))
        else $error("clipped set on unsaturated output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_clipped))
        else $error("stalled result dropped or changed");

endmodule

bind iir_filter_with_initial_state iir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_iir_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out),
    .m_clipped    (m_clipped)
);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iir_pkg::*;

    localparam int ORDER     = 2;
    localparam int FRAC_BITS = 14;
    localparam int SMP_BITS  = 16;
    localparam int NUM_COEFS = 7;
    localparam int RAND_RUNS = 13;
    localparam int RUN_LEN   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [COEF_BITS-1:0] COEF_MAX = 18'sh1FFFF;
    localparam logic signed [COEF_BITS-1:0] COEF_MIN = 18'sh20000;
    localparam logic signed [SMP_BITS-1:0]  SMP_MAX  = 16'sh7FFF;
    localparam logic signed [SMP_BITS-1:0]  SMP_MIN  = 16'sh8000;

    typedef struct packed {
        logic signed [SMP_BITS-1:0] sample;
        logic                       clip;
    } filt_out_t;

    class biquad_tracker;
        longint    coef [NUM_COEFS];
        longint    s0;
        longint    s1;
        int        mismatches;
        filt_out_t expected_out [$];

        function new();
            foreach (coef[k]) coef[k] = 0;
            coef[REG_FF_COEF_0] = 64'sd1 <<< FRAC_BITS;
            s0 = 0;
            s1 = 0;
            mismatches = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_BITS-1:0] v);
            // writes past the last register are dropped by the block
            if (idx <= REG_INIT_GAIN_1)
                coef[idx] = v;
        endfunction

        function longint clamp_state(longint v);
            longint hi;
            hi = (64'sd1 <<< (STATE_BITS - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void note_sample(logic signed [SMP_BITS-1:0] x, logic first);
            longint    xs;
            longint    acc;
            longint    y;
            longint    y_hi;
            filt_out_t res;
            xs = x;
            y_hi = (64'sd1 <<< (SMP_BITS - 1)) - 1;
            res.clip = 1'b0;
            if (first) begin
                s0 = clamp_state(coef[REG_INIT_GAIN_0] * xs);
                s1 = (ORDER >= 2) ? clamp_state(coef[REG_INIT_GAIN_1] * xs) : 0;
            end
            acc = coef[REG_FF_COEF_0] * xs + s0 + (64'sd1 <<< (FRAC_BITS - 1));
            y = acc >>> FRAC_BITS;
            if (y > y_hi) begin
                y = y_hi;
                res.clip = 1'b1;
            end else if (y < -y_hi - 1) begin
                y = -y_hi - 1;
                res.clip = 1'b1;
            end
            // saturated y feeds the feedback terms
            if (ORDER >= 2) begin
                s0 = clamp_state(coef[REG_FF_COEF_1] * xs - coef[REG_FB_COEF_1] * y + s1);
                s1 = clamp_state(coef[REG_FF_COEF_2] * xs - coef[REG_FB_COEF_2] * y);
            end else begin
                s0 = clamp_state(coef[REG_FF_COEF_1] * xs - coef[REG_FB_COEF_1] * y);
                s1 = 0;
            end
            res.sample = y[SMP_BITS-1:0];
            expected_out.push_back(res);
        endfunction

        function void check_output(logic signed [SMP_BITS-1:0] got, logic got_clip);
            filt_out_t exp_res;
            if (expected_out.size() == 0) begin
                $error("unexpected output transfer: sample_out %0d clipped %0b", got, got_clip);
                mismatches++;
                return;
            end
            exp_res = expected_out.pop_front();
            if (got !== exp_res.sample) begin
                $error("sample_out: expected %0d, actual %0d", exp_res.sample, got);
                mismatches++;
            end
            if (got_clip !== exp_res.clip) begin
                $error("clipped: expected %0b, actual %0b", exp_res.clip, got_clip);
                mismatches++;
            end
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [COEF_BITS-1:0]         cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [SMP_BITS-1:0]   s_sample_in;
    logic                         s_first_sample;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [SMP_BITS-1:0]   m_sample_out;
    logic                         m_clipped;

    biquad_tracker tracker;
    int            tx_mode;
    int            rx_mode;
    int            stall_left = 0;

    iir_filter_with_initial_state #(
        .FILTER_ORDER   (ORDER),
        .COEF_FRAC_BITS (FRAC_BITS),
        .SAMPLE_BITS    (SMP_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .s_first_sample (s_first_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_clipped      (m_clipped)
    );

    always #6 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // result side: check every transfer, then decide on back-pressure for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_output(m_sample_out, m_clipped);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_mode != 0 && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_mode == 0 || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [COEF_BITS-1:0] extreme_coef();
        case ($urandom_range(0, 3))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [SMP_BITS-1:0] next_sample(logic signed [SMP_BITS-1:0] prev);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return SMP_BITS'($urandom);
        if (r < 7)
            return SMP_BITS'(int'($urandom_range(0, 512)) - 256);
        if (r == 7)
            return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
        // slow drift around the previous sample
        return prev + SMP_BITS'(int'($urandom_range(0, 64)) - 32);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic signed [COEF_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        tracker.set_coef(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_coefs(input logic signed [COEF_BITS-1:0] c [NUM_COEFS]);
        for (int k = 0; k < NUM_COEFS; k++)
            write_reg(CFG_IDX_W'(k), c[k]);
    endtask

    // valid stays up across back-to-back transfers; it only drops ahead of a gap
    task automatic send_sample(input logic signed [SMP_BITS-1:0] x, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_in    <= x;
        s_first_sample <= first;
        do
            @(posedge aclk);
        while (!s_ready);
        tracker.note_sample(x, first);
    endtask

    // hold off until every result has come back and the sequencer is idle
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    initial begin
        logic signed [COEF_BITS-1:0] c [NUM_COEFS];
        logic signed [SMP_BITS-1:0]  x;
        logic                        first;
        int                          kind;
        int                          a2;

        tracker = new();
        tx_mode    = 0;
        rx_mode    = 0;
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_sample_in    <= '0;
        s_first_sample <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset coefficients pass samples straight through; a write past the map is dropped
        write_reg(REG_UNUSED, COEF_MAX);
        send_sample(16'sd0, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd12345, 1'b0);
        drain();

        // largest coefficients: saturation both ways, start gains at their maximum
        tx_mode = 1;
        rx_mode = 1;
        foreach (c[k]) c[k] = COEF_MAX;
        load_coefs(c);
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh5555, 1'b0);
        drain();

        foreach (c[k]) c[k] = COEF_MIN;
        load_coefs(c);
        send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        drain();

        // stable low-pass, step input from start states set by the start gains g0 and g1
        c[REG_FF_COEF_0]   = 18'sd1106;
        c[REG_FF_COEF_1]   = 18'sd2212;
        c[REG_FF_COEF_2]   = 18'sd1106;
        c[REG_FB_COEF_1]   = -18'sd18727;
        c[REG_FB_COEF_2]   = 18'sd6764;
        c[REG_INIT_GAIN_0] = 18'sd8000;
        c[REG_INIT_GAIN_1] = -18'sd3000;
        load_coefs(c);
        send_sample(16'sd10000, 1'b1);
        repeat (6) send_sample(16'sd10000, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        drain();

        for (int run = 0; run < RAND_RUNS; run++) begin
            kind    = run % 3;
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            for (int k = 0; k < NUM_COEFS; k++) begin
                if (kind == 0) begin
                    c[k] = COEF_BITS'($urandom);
                end else if (kind == 2) begin
                    c[k] = extreme_coef();
                end else begin
                    c[k] = COEF_BITS'(int'($urandom_range(0, 32768)) - 16384);
                end
            end
            if (kind == 1) begin
                // keep the poles inside the unit circle
                a2 = $urandom_range(0, 12000);
                c[REG_FB_COEF_2]   = COEF_BITS'(a2);
                c[REG_FB_COEF_1]   = COEF_BITS'(int'($urandom_range(0, 2 * (15384 + a2)))
                                                - (15384 + a2));
                c[REG_INIT_GAIN_0] = COEF_BITS'(int'($urandom_range(0, 131072)) - 65536);
                c[REG_INIT_GAIN_1] = COEF_BITS'(int'($urandom_range(0, 131072)) - 65536);
            end
            load_coefs(c);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, COEF_BITS'($urandom));
            x = 16'sd0;
            for (int i = 0; i < RUN_LEN; i++) begin
                x = next_sample(x);
                first = (i == 0) || ($urandom_range(0, 39) == 0);
                send_sample(x, first);
            end
            drain();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
